// File: design/masked_channel_blend_top_defines.svh
// Assertion macros used by the checker file of the blend block.
// Every property is clocked on clk and switched off while rst_n is low.
`ifndef MASKED_CHANNEL_BLEND_TOP_DEFINES_SVH
`define MASKED_CHANNEL_BLEND_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/mcb_pkg.sv
package mcb_pkg;

    // Fixed-point layout of the channels and of the weight.
    localparam int CH_W        = 16;
    localparam int NCH         = 4;
    localparam int FRAC_BITS   = 12;
    localparam int WEIGHT_BITS = 12;
    localparam int WEIGHT_FULL = 1 << WEIGHT_BITS;
    localparam int WGT_W       = WEIGHT_BITS + 1;

    // Intermediate widths, all derived from the channel and weight layout.
    localparam int OP_W   = CH_W + 2;
    localparam int PROD_W = 2 * OP_W;
    localparam int R_W    = PROD_W - FRAC_BITS + 2;
    localparam int DIFF_W = R_W + 1;
    localparam int LERP_W = DIFF_W + WGT_W + 1;
    localparam int SUM_W  = DIFF_W + 1;

    localparam int ONE    = 1 << FRAC_BITS;
    localparam int CH_MAX = (1 << (CH_W - 1)) - 1;
    localparam int CH_MIN = -(1 << (CH_W - 1));

    localparam int STAGES = 5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = WGT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'b1;

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_SUB    = 3'd1,
        MODE_MIN    = 3'd2,
        MODE_MAX    = 3'd3,
        MODE_MIX    = 3'd4,
        MODE_SCREEN = 3'd5,
        MODE_MUL    = 3'd6
    } mode_t;

    typedef logic signed [CH_W-1:0]   chan_t;
    typedef logic signed [OP_W-1:0]   op_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [R_W-1:0]    res_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [LERP_W-1:0] lerp_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Result shape that travels beside the channel data.
    typedef struct packed {
        logic           is_color;
        logic [NCH-1:0] mask;
    } meta_t;

endpackage

// File: design/masked_channel_blend_top.sv
// Channel   Handshake                   Payload
// --------  --------------------------  ------------------------------------------
// input     in_valid / in_ready         base_is_color, base_mask, base_c0..c3,
//                                       blend_is_color, blend_mask, blend_c0..c3
// output    out_valid / out_ready       out_is_color, out_mask, out_c0..c3
// config    cfg_wr_en (no wait)         cfg_index, cfg_data
//
// One transfer per cycle is sustained while the output is not stalled; the lane pipeline
// has five registers and holds two multipliers per channel (mode product, then weight
// product) in separate stages.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the mode to multiply
// and the weight to zero.
// A stall at the output holds each stage in place; a stage takes new data whenever
// it is empty or the stage after it moves, so no transfer is lost or repeated.
module masked_channel_blend_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mcb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcb_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               base_is_color,
    input  logic [mcb_pkg::NCH-1:0]            base_mask,
    input  logic signed [mcb_pkg::CH_W-1:0]    base_c0,
    input  logic signed [mcb_pkg::CH_W-1:0]    base_c1,
    input  logic signed [mcb_pkg::CH_W-1:0]    base_c2,
    input  logic signed [mcb_pkg::CH_W-1:0]    base_c3,
    input  logic                               blend_is_color,
    input  logic [mcb_pkg::NCH-1:0]            blend_mask,
    input  logic signed [mcb_pkg::CH_W-1:0]    blend_c0,
    input  logic signed [mcb_pkg::CH_W-1:0]    blend_c1,
    input  logic signed [mcb_pkg::CH_W-1:0]    blend_c2,
    input  logic signed [mcb_pkg::CH_W-1:0]    blend_c3,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_is_color,
    output logic [mcb_pkg::NCH-1:0]            out_mask,
    output logic signed [mcb_pkg::CH_W-1:0]    out_c0,
    output logic signed [mcb_pkg::CH_W-1:0]    out_c1,
    output logic signed [mcb_pkg::CH_W-1:0]    out_c2,
    output logic signed [mcb_pkg::CH_W-1:0]    out_c3
);

    localparam int NCH    = mcb_pkg::NCH;
    localparam int STAGES = mcb_pkg::STAGES;

    localparam mcb_pkg::op_t   ONE_OP = mcb_pkg::op_t'(mcb_pkg::ONE);
    localparam mcb_pkg::res_t  ONE_R  = mcb_pkg::res_t'(mcb_pkg::ONE);
    localparam mcb_pkg::prod_t HALF_P = mcb_pkg::prod_t'(1 << (mcb_pkg::FRAC_BITS - 1));
    localparam mcb_pkg::lerp_t HALF_L = mcb_pkg::lerp_t'(1 << (mcb_pkg::WEIGHT_BITS - 1));
    localparam mcb_pkg::sum_t  SAT_HI = mcb_pkg::sum_t'(mcb_pkg::CH_MAX);
    localparam mcb_pkg::sum_t  SAT_LO = mcb_pkg::sum_t'(mcb_pkg::CH_MIN);
    localparam logic [mcb_pkg::WGT_W-1:0] W_FULL = mcb_pkg::WGT_W'(mcb_pkg::WEIGHT_FULL);

    // ------------------------------------------------------------------
    // Configuration registers. The user must change them only while the block
    // is idle; the block itself does not enforce this. Every stage reads them directly.
    // ------------------------------------------------------------------
    logic [2:0]                 mode_reg;
    logic [mcb_pkg::WGT_W-1:0]  weight_reg;
    logic [mcb_pkg::WGT_W-1:0]  w_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= mcb_pkg::MODE_MUL;
            weight_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mcb_pkg::CFG_MODE:   mode_reg   <= cfg_data[2:0];
                mcb_pkg::CFG_WEIGHT: weight_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // A weight above full blend acts as full blend.
    assign w_eff = (weight_reg > W_FULL) ? W_FULL : weight_reg;

    // ------------------------------------------------------------------
    // Pipeline control. Each stage moves when it is empty or when the
    // stage after it moves; valid bits travel with the data.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] up_valid;

    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        up_valid[0] = in_valid;
        for (int k = 1; k < STAGES; k++)
        begin
            up_valid[k] = valid_reg[k-1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            valid_next[k] = stage_ready[k] ? up_valid[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: resolve the channel set, broadcast scalars and pick the
    // operands of the mode multiplier (screen works on one minus each).
    // ------------------------------------------------------------------
    mcb_pkg::chan_t base_ch  [NCH];
    mcb_pkg::chan_t blend_ch [NCH];

    assign base_ch[0]  = base_c0;
    assign base_ch[1]  = base_c1;
    assign base_ch[2]  = base_c2;
    assign base_ch[3]  = base_c3;
    assign blend_ch[0] = blend_c0;
    assign blend_ch[1] = blend_c1;
    assign blend_ch[2] = blend_c2;
    assign blend_ch[3] = blend_c3;

    mcb_pkg::meta_t s1_meta_reg, s1_meta_next;
    mcb_pkg::chan_t s1_a_reg  [NCH];
    mcb_pkg::chan_t s1_a_next [NCH];
    mcb_pkg::chan_t s1_b_reg  [NCH];
    mcb_pkg::chan_t s1_b_next [NCH];
    mcb_pkg::op_t   s1_x_reg  [NCH];
    mcb_pkg::op_t   s1_x_next [NCH];
    mcb_pkg::op_t   s1_y_reg  [NCH];
    mcb_pkg::op_t   s1_y_next [NCH];
    logic [NCH-1:0] s1_en_reg, s1_en_next;

    always_comb
    begin
        logic [NCH-1:0] set;
        set = base_is_color ? base_mask : blend_mask;
        s1_meta_next.is_color = base_is_color || blend_is_color;
        s1_meta_next.mask     = s1_meta_next.is_color ? set : '0;
        for (int i = 0; i < NCH; i++)
        begin
            s1_a_next[i] = base_is_color  ? base_ch[i]  : base_c0;
            s1_b_next[i] = blend_is_color ? blend_ch[i] : blend_c0;
            if (!s1_meta_next.is_color)
            begin
                // Two scalars: only channel zero carries a value.
                s1_en_next[i] = (i == 0);
            end
            else
            begin
                s1_en_next[i] = set[i] && (!blend_is_color || blend_mask[i]);
            end
            if (mode_reg == mcb_pkg::MODE_SCREEN)
            begin
                s1_x_next[i] = ONE_OP - mcb_pkg::op_t'(s1_a_next[i]);
                s1_y_next[i] = ONE_OP - mcb_pkg::op_t'(s1_b_next[i]);
            end
            else
            begin
                s1_x_next[i] = mcb_pkg::op_t'(s1_a_next[i]);
                s1_y_next[i] = mcb_pkg::op_t'(s1_b_next[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            s1_meta_reg <= s1_meta_next;
            s1_en_reg   <= s1_en_next;
            s1_a_reg    <= s1_a_next;
            s1_b_reg    <= s1_b_next;
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: mode product per channel, and the modes that need no
    // multiplier.
    // ------------------------------------------------------------------
    mcb_pkg::meta_t s2_meta_reg;
    logic [NCH-1:0] s2_en_reg;
    mcb_pkg::chan_t s2_a_reg     [NCH];
    mcb_pkg::prod_t s2_p_reg     [NCH];
    mcb_pkg::prod_t s2_p_next    [NCH];
    mcb_pkg::res_t  s2_s_reg     [NCH];
    mcb_pkg::res_t  s2_s_next    [NCH];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            s2_p_next[i] = mcb_pkg::prod_t'(s1_x_reg[i]) * mcb_pkg::prod_t'(s1_y_reg[i]);
            case (mode_reg)
                mcb_pkg::MODE_ADD:
                    s2_s_next[i] = mcb_pkg::res_t'(s1_a_reg[i]) + mcb_pkg::res_t'(s1_b_reg[i]);
                mcb_pkg::MODE_SUB:
                    s2_s_next[i] = mcb_pkg::res_t'(s1_a_reg[i]) - mcb_pkg::res_t'(s1_b_reg[i]);
                mcb_pkg::MODE_MIN:
                    s2_s_next[i] = (s1_a_reg[i] < s1_b_reg[i]) ?
                                   mcb_pkg::res_t'(s1_a_reg[i]) : mcb_pkg::res_t'(s1_b_reg[i]);
                mcb_pkg::MODE_MAX:
                    s2_s_next[i] = (s1_a_reg[i] > s1_b_reg[i]) ?
                                   mcb_pkg::res_t'(s1_a_reg[i]) : mcb_pkg::res_t'(s1_b_reg[i]);
                mcb_pkg::MODE_MIX:
                    s2_s_next[i] = mcb_pkg::res_t'(s1_b_reg[i]);
                default:
                    s2_s_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_en_reg   <= s1_en_reg;
            s2_a_reg    <= s1_a_reg;
            s2_p_reg    <= s2_p_next;
            s2_s_reg    <= s2_s_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round the product (half up), form the mode result and its
    // distance from the base.
    // ------------------------------------------------------------------
    mcb_pkg::meta_t s3_meta_reg;
    logic [NCH-1:0] s3_en_reg;
    mcb_pkg::chan_t s3_a_reg     [NCH];
    mcb_pkg::diff_t s3_d_reg     [NCH];
    mcb_pkg::diff_t s3_d_next    [NCH];

    always_comb
    begin
        mcb_pkg::prod_t rnd;
        mcb_pkg::res_t  sh;
        mcb_pkg::res_t  r;
        for (int i = 0; i < NCH; i++)
        begin
            rnd = s2_p_reg[i] + HALF_P;
            sh  = mcb_pkg::res_t'(rnd >>> mcb_pkg::FRAC_BITS);
            case (mode_reg)
                mcb_pkg::MODE_ADD,
                mcb_pkg::MODE_SUB,
                mcb_pkg::MODE_MIN,
                mcb_pkg::MODE_MAX,
                mcb_pkg::MODE_MIX:    r = s2_s_reg[i];
                mcb_pkg::MODE_SCREEN: r = ONE_R - sh;
                default:              r = sh;
            endcase
            s3_d_next[i] = mcb_pkg::diff_t'(r) - mcb_pkg::diff_t'(s2_a_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[2])
        begin
            s3_meta_reg <= s2_meta_reg;
            s3_en_reg   <= s2_en_reg;
            s3_a_reg    <= s2_a_reg;
            s3_d_reg    <= s3_d_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale the distance by the weight.
    // ------------------------------------------------------------------
    mcb_pkg::meta_t s4_meta_reg;
    logic [NCH-1:0] s4_en_reg;
    mcb_pkg::chan_t s4_a_reg     [NCH];
    mcb_pkg::lerp_t s4_l_reg     [NCH];
    mcb_pkg::lerp_t s4_l_next    [NCH];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            s4_l_next[i] = mcb_pkg::lerp_t'(s3_d_reg[i]) *
                           mcb_pkg::lerp_t'($signed({1'b0, w_eff}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[3])
        begin
            s4_meta_reg <= s3_meta_reg;
            s4_en_reg   <= s3_en_reg;
            s4_a_reg    <= s3_a_reg;
            s4_l_reg    <= s4_l_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: round, add back to the base and saturate. Unblended
    // channels carry the base; a scalar result zeroes channels one to three.
    // This stage is the output register.
    // ------------------------------------------------------------------
    mcb_pkg::meta_t s5_meta_reg;
    mcb_pkg::chan_t s5_c_reg     [NCH];
    mcb_pkg::chan_t s5_c_next    [NCH];

    always_comb
    begin
        mcb_pkg::lerp_t rl;
        mcb_pkg::diff_t t;
        mcb_pkg::sum_t  sum;
        mcb_pkg::chan_t sat;
        for (int i = 0; i < NCH; i++)
        begin
            rl  = s4_l_reg[i] + HALF_L;
            t   = mcb_pkg::diff_t'(rl >>> mcb_pkg::WEIGHT_BITS);
            sum = mcb_pkg::sum_t'(s4_a_reg[i]) + mcb_pkg::sum_t'(t);
            if (sum > SAT_HI)
            begin
                sat = mcb_pkg::chan_t'(SAT_HI);
            end
            else if (sum < SAT_LO)
            begin
                sat = mcb_pkg::chan_t'(SAT_LO);
            end
            else
            begin
                sat = mcb_pkg::chan_t'(sum);
            end
            if (!s4_meta_reg.is_color && (i != 0))
            begin
                s5_c_next[i] = '0;
            end
            else if (s4_en_reg[i])
            begin
                s5_c_next[i] = sat;
            end
            else
            begin
                s5_c_next[i] = s4_a_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[4])
        begin
            s5_meta_reg <= s4_meta_reg;
            s5_c_reg    <= s5_c_next;
        end
    end

    assign out_is_color = s5_meta_reg.is_color;
    assign out_mask     = s5_meta_reg.mask;
    assign out_c0       = s5_c_reg[0];
    assign out_c1       = s5_c_reg[1];
    assign out_c2       = s5_c_reg[2];
    assign out_c3       = s5_c_reg[3];

endmodule

// File: design/mcb_checker.sv
`include "masked_channel_blend_top_defines.svh"

module mcb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            out_is_color,
    input logic [mcb_pkg::NCH-1:0]         out_mask,
    input logic signed [mcb_pkg::CH_W-1:0] out_c0,
    input logic signed [mcb_pkg::CH_W-1:0] out_c1,
    input logic signed [mcb_pkg::CH_W-1:0] out_c2,
    input logic signed [mcb_pkg::CH_W-1:0] out_c3
);

    // A stalled result stays on the port unchanged.
    `MCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_c0) && $stable(out_c1) && $stable(out_c2) && $stable(out_c3) && $stable(out_mask) && $stable(out_is_color))

    // A scalar result carries no mask and no further channels.
    `MCB_ASSERT_SAME(a_scalar_zero, out_valid && !out_is_color, (out_mask == '0) && (out_c1 == '0) && (out_c2 == '0) && (out_c3 == '0))

    // When the output moves or is empty, the whole pipeline can move.
    `MCB_ASSERT_SAME(a_ready_chain, out_ready || !out_valid, in_ready)

endmodule

bind masked_channel_blend_top mcb_checker u_mcb_checker (.*);
